// File: sv/dpbp_pkg.sv
package dpbp_pkg;

    // Default geometry of the pixel counters and the depth sample.
    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    // Fixed field widths.
    localparam int DEPTH_PORT_BITS = 16;
    localparam int DIM_BITS        = 13;
    localparam int COEF_BITS       = 32;
    localparam int COEF_COUNT      = 9;
    localparam int OUT_BITS        = 48;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_INDEX_BITS  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW0_AB     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW0C_ROW1A = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW1_BC     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW2_AB     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW2_C      = 3'd6;

    // Reset values of the registers.
    localparam logic [DIM_BITS-1:0]      WIDTH_RESET  = 13'd640;
    localparam logic [DIM_BITS-1:0]      HEIGHT_RESET = 13'd480;
    localparam logic [COEF_BITS-1:0]     M22_RESET    = 32'h0100_0000;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

endpackage

// File: sv/dpbp_queue.sv
module dpbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dpbp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/dpbp_front.sv
module dpbp_front #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpbp_pkg::DEPTH_BITS_DEF,
    parameter int ENTRY_BITS = 2 * (COORD_BITS + DEPTH_BITS) + DEPTH_BITS + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pix_valid,
    output logic                                o_pix_stall,
    input  logic [dpbp_pkg::DEPTH_PORT_BITS-1:0] i_depth,
    input  logic [dpbp_pkg::DIM_BITS-1:0]       i_image_width,
    input  logic [dpbp_pkg::DIM_BITS-1:0]       i_image_height,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output logic [ENTRY_BITS-1:0]               o_entry
);

    localparam int U_BITS = COORD_BITS + DEPTH_BITS;
    localparam int DIM_W  = (COORD_BITS + 1 > dpbp_pkg::DIM_BITS) ?
                            COORD_BITS + 1 : dpbp_pkg::DIM_BITS;
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'({1'b1, {COORD_BITS{1'b0}}});

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;
    logic [DIM_W-1:0]      width_ext;
    logic [DIM_W-1:0]      height_ext;
    logic [DIM_W-1:0]      eff_width;
    logic [DIM_W-1:0]      eff_height;
    logic                  last_col;
    logic                  last_row;
    logic [DEPTH_BITS-1:0] depth;
    logic [U_BITS-1:0]     u_term;
    logic [U_BITS-1:0]     v_term;
    logic                  point_ok;
    logic                  transfer;

    // A size of zero or beyond the counter range means the full range.
    assign width_ext  = DIM_W'(i_image_width);
    assign height_ext = DIM_W'(i_image_height);
    assign eff_width  = (width_ext == '0 || width_ext > MAX_DIM) ? MAX_DIM : width_ext;
    assign eff_height = (height_ext == '0 || height_ext > MAX_DIM) ? MAX_DIM : height_ext;

    // A counter at or past its last position wraps on the next pixel.
    assign last_col = (DIM_W'(r_col) + DIM_W'(1)) >= eff_width;
    assign last_row = (DIM_W'(r_row) + DIM_W'(1)) >= eff_height;

    assign transfer    = i_pix_valid && !i_queue_full;
    assign o_pix_stall = i_queue_full;
    assign o_push      = transfer;

    // Scale the pixel position by its depth and classify the sample.
    assign depth    = i_depth[DEPTH_BITS-1:0];
    assign u_term   = U_BITS'(r_col) * U_BITS'(depth);
    assign v_term   = U_BITS'(r_row) * U_BITS'(depth);
    assign point_ok = (depth > DEPTH_BITS'(1));
    assign o_entry  = {last_col && last_row, point_ok, depth, v_term, u_term};

    // Raster position for the next pixel.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + COORD_BITS'(1);
        end else begin
            n_col = r_col + COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (transfer) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: sv/dpbp_back.sv
module dpbp_back #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpbp_pkg::DEPTH_BITS_DEF,
    parameter int ENTRY_BITS = 2 * (COORD_BITS + DEPTH_BITS) + DEPTH_BITS + 2
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic [dpbp_pkg::COEF_COUNT-1:0][dpbp_pkg::COEF_BITS-1:0] i_coef,
    input  logic                                            i_queue_empty,
    input  logic [ENTRY_BITS-1:0]                           i_entry,
    output logic                                            o_pop,
    output logic                                            o_pt_valid,
    input  logic                                            i_pt_stall,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]            o_point_x,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]            o_point_y,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]            o_point_z,
    output logic                                            o_point_valid,
    output logic                                            o_frame_last
);

    localparam int U_BITS  = COORD_BITS + DEPTH_BITS;
    localparam int PROD_W  = U_BITS + dpbp_pkg::COEF_BITS + 1;
    localparam int SUM_MIN = dpbp_pkg::OUT_BITS + 9;
    localparam int SUM_W   = (PROD_W + 2 > SUM_MIN) ? PROD_W + 2 : SUM_MIN;
    localparam int SH_W    = SUM_W - 8;
    localparam int OB      = dpbp_pkg::OUT_BITS;

    logic [U_BITS-1:0]     u_term;
    logic [U_BITS-1:0]     v_term;
    logic [DEPTH_BITS-1:0] depth;
    logic                  entry_ok;
    logic                  entry_last;
    logic                  advance;

    logic signed [PROD_W-1:0] r_prod [dpbp_pkg::COEF_COUNT];
    logic                     r_s1_valid;
    logic                     r_s1_ok;
    logic                     r_s1_last;
    logic signed [SUM_W-1:0]  r_sum [3];
    logic                     r_s2_valid;
    logic                     r_s2_ok;
    logic                     r_s2_last;
    logic                     r_out_valid;

    // Round to Q.16 (the bias is already in the sum) and clamp to 48 bits.
    function automatic logic [OB-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic [SH_W-1:0]    sh;
        logic [SH_W-OB:0]   top;
        logic [OB-1:0]      res;
        sh  = s[SUM_W-1:8];
        top = sh[SH_W-1:OB-1];
        if (top == '0 || top == '1) begin
            res = sh[OB-1:0];
        end else if (sh[SH_W-1]) begin
            res = {1'b1, {(OB-1){1'b0}}};
        end else begin
            res = {1'b0, {(OB-1){1'b1}}};
        end
        return res;
    endfunction

    assign {entry_last, entry_ok, depth, v_term, u_term} = i_entry;

    // The whole pipeline moves when the output register is free or drains.
    assign advance    = !r_out_valid || !i_pt_stall;
    assign o_pop      = advance && !i_queue_empty;
    assign o_pt_valid = r_out_valid;

    // First stage: the nine products of the matrix and the scaled vector.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[3*i]     <= $signed(i_coef[3*i])     * $signed({1'b0, u_term});
                r_prod[3*i + 1] <= $signed(i_coef[3*i + 1]) * $signed({1'b0, v_term});
                r_prod[3*i + 2] <= $signed(i_coef[3*i + 2]) *
                                   $signed({1'b0, U_BITS'(depth)});
            end
            r_s1_ok   <= entry_ok;
            r_s1_last <= entry_last;
        end
    end

    // Second stage: row sums with the rounding bias of half a Q.16 step.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= SUM_W'(r_prod[3*i]) + SUM_W'(r_prod[3*i + 1]) +
                            SUM_W'(r_prod[3*i + 2]) + SUM_W'(128);
            end
            r_s2_ok   <= r_s1_ok;
            r_s2_last <= r_s1_last;
        end
    end

    // Output register: an invalid depth gives the zero point.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_point_x     <= r_s2_ok ? round_sat(r_sum[0]) : '0;
            o_point_y     <= r_s2_ok ? round_sat(r_sum[1]) : '0;
            o_point_z     <= r_s2_ok ? round_sat(r_sum[2]) : '0;
            o_point_valid <= r_s2_ok;
            o_frame_last  <= r_s2_last;
        end
    end

    // Occupancy of each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= !i_queue_empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

endmodule

// File: sv/depth_pixel_back_projection.sv
// A result passes the queue write, product stage, sum stage and output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the fully
// pipelined nine-multiplier back end.
// A four-entry queue decouples the raster counters from the arithmetic pipeline.
// Reset (synchronous, active low) clears the counters, the queue and the stage
// occupancy, and loads 640 by 480 with an identity-free matrix whose m22 is 1.0.
module depth_pixel_back_projection #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpbp_pkg::DEPTH_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [dpbp_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                    i_pix_valid,
    output logic                                    o_pix_stall,
    input  logic [dpbp_pkg::DEPTH_PORT_BITS-1:0]    i_depth,
    output logic                                    o_pt_valid,
    input  logic                                    i_pt_stall,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]    o_point_x,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]    o_point_y,
    output logic signed [dpbp_pkg::OUT_BITS-1:0]    o_point_z,
    output logic                                    o_point_valid,
    output logic                                    o_frame_last
);

    localparam int U_BITS     = COORD_BITS + DEPTH_BITS;
    localparam int ENTRY_BITS = 2 * U_BITS + DEPTH_BITS + 2;

    logic [dpbp_pkg::DIM_BITS-1:0]      r_image_width;
    logic [dpbp_pkg::DIM_BITS-1:0]      r_image_height;
    logic [dpbp_pkg::CFG_DATA_BITS-1:0] r_coef_row0_ab;
    logic [dpbp_pkg::CFG_DATA_BITS-1:0] r_coef_row0c_row1a;
    logic [dpbp_pkg::CFG_DATA_BITS-1:0] r_coef_row1_bc;
    logic [dpbp_pkg::CFG_DATA_BITS-1:0] r_coef_row2_ab;
    logic [dpbp_pkg::COEF_BITS-1:0]     r_coef_row2_c;

    logic [dpbp_pkg::COEF_COUNT-1:0][dpbp_pkg::COEF_BITS-1:0] coef;

    logic                  push;
    logic                  pop;
    logic                  queue_empty;
    logic                  queue_full;
    logic [ENTRY_BITS-1:0] push_entry;
    logic [ENTRY_BITS-1:0] pop_entry;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width      <= dpbp_pkg::WIDTH_RESET;
            r_image_height     <= dpbp_pkg::HEIGHT_RESET;
            r_coef_row0_ab     <= '0;
            r_coef_row0c_row1a <= '0;
            r_coef_row1_bc     <= '0;
            r_coef_row2_ab     <= '0;
            r_coef_row2_c      <= dpbp_pkg::M22_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpbp_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[dpbp_pkg::DIM_BITS-1:0];
                end
                dpbp_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[dpbp_pkg::DIM_BITS-1:0];
                end
                dpbp_pkg::REG_COEF_ROW0_AB: begin
                    r_coef_row0_ab <= i_cfg_data;
                end
                dpbp_pkg::REG_COEF_ROW0C_ROW1A: begin
                    r_coef_row0c_row1a <= i_cfg_data;
                end
                dpbp_pkg::REG_COEF_ROW1_BC: begin
                    r_coef_row1_bc <= i_cfg_data;
                end
                dpbp_pkg::REG_COEF_ROW2_AB: begin
                    r_coef_row2_ab <= i_cfg_data;
                end
                dpbp_pkg::REG_COEF_ROW2_C: begin
                    r_coef_row2_c <= i_cfg_data[dpbp_pkg::COEF_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Matrix entries in row-major order.
    assign coef[0] = r_coef_row0_ab[31:0];
    assign coef[1] = r_coef_row0_ab[63:32];
    assign coef[2] = r_coef_row0c_row1a[31:0];
    assign coef[3] = r_coef_row0c_row1a[63:32];
    assign coef[4] = r_coef_row1_bc[31:0];
    assign coef[5] = r_coef_row1_bc[63:32];
    assign coef[6] = r_coef_row2_ab[31:0];
    assign coef[7] = r_coef_row2_ab[63:32];
    assign coef[8] = r_coef_row2_c;

    dpbp_front #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_pix_valid),
        .o_pix_stall    (o_pix_stall),
        .i_depth        (i_depth),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    dpbp_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (dpbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    dpbp_back #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coef        (coef),
        .i_queue_empty (queue_empty),
        .i_entry       (pop_entry),
        .o_pop         (pop),
        .o_pt_valid    (o_pt_valid),
        .i_pt_stall    (i_pt_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_point_valid (o_point_valid),
        .o_frame_last  (o_frame_last)
    );

endmodule
